// ===== hw/rtl/sfrb_pkg.sv =====
// Package: shared types and codes of the SLIP frame receive buffer.
`timescale 1ns / 1ps
package sfrb_pkg;

   localparam logic [1:0] STATUS_BYTE    = 2'd0;
   localparam logic [1:0] STATUS_NONE    = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;

   localparam logic ACTION_RECEIVE = 1'b0;
   localparam logic ACTION_READ    = 1'b1;

   localparam logic [2:0] REG_END_CODE     = 3'd0;
   localparam logic [2:0] REG_ESCAPE_CODE  = 3'd1;
   localparam logic [2:0] REG_ESC_END_CODE = 3'd2;
   localparam logic [2:0] REG_ESC_ESC_CODE = 3'd3;
   localparam logic [2:0] REG_MIN_LEN      = 3'd4;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
      logic [6:0] max_len;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] data_byte;
      logic       last;
      logic [6:0] frame_len;
   } rsp_type;

   typedef struct packed {
      logic [7:0] end_code;
      logic [7:0] escape_code;
      logic [7:0] escaped_end_code;
      logic [7:0] escaped_escape_code;
      logic [6:0] min_frame_len;
   } cfg_type;

endpackage

// ===== hw/rtl/sfrb_cmd_queue.sv =====
// Command queue: short FIFO between the request front end and the engine.
`timescale 1ns / 1ps
module sfrb_cmd_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfrb_pkg::req_type push_data,
   input  logic             pop,
   output logic             empty,
   output logic             full,
   output sfrb_pkg::req_type head
);
   import sfrb_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   req_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]     cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (PW+1)'(DEPTH));
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

// ===== hw/rtl/sfrb_engine.sv =====
// Engine: un-escapes line bytes into the store, keeps slots, plays frames out.
`timescale 1ns / 1ps
module sfrb_engine #(
   parameter int STORE_BYTES = 256,
   parameter int FRAME_SLOTS = 8,
   parameter int MAX_READ    = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  sfrb_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  sfrb_pkg::req_type cmd,
   output logic              cmd_pop,
   output logic              rsp_strobe,
   output sfrb_pkg::rsp_type rsp_data
);
   import sfrb_pkg::*;

   localparam int AW = $clog2(STORE_BYTES);
   localparam int SW = $clog2(FRAME_SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_CHECK, ST_FETCH, ST_PLAY
   } state_type;

   state_type     state_ff;
   logic [7:0]    store_mem [STORE_BYTES];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] start_ff [FRAME_SLOTS];
   logic [15:0]   len_ff [FRAME_SLOTS];
   logic [SW-1:0] wslot_ff, rslot_ff, scan_ff;
   logic [AW-1:0] wpos_ff;
   logic          wrapped_ff, esc_ff;
   logic [15:0]   cur_ff;
   logic [6:0]    maxl_ff, flen_ff, left_ff;
   logic [AW-1:0] rpos_ff;
   logic          wrap_rd_ff;

   logic          idle;
   logic [6:0]    max_clip;
   logic [SW-1:0] ws_nx;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_val;
   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic [15:0]   slen;
   logic [AW:0]   span;

   assign idle    = (state_ff == ST_IDLE);
   assign cmd_pop = idle && cmd_valid;
   assign max_clip = (cmd.max_len > 7'(MAX_READ)) ? 7'(MAX_READ) : cmd.max_len;
   assign ws_nx   = (wslot_ff == SW'(FRAME_SLOTS - 1)) ? '0 : wslot_ff + 1'b1;
   assign slen    = len_ff[scan_ff];
   assign span    = {1'b0, start_ff[scan_ff]} + (AW+1)'(slen[6:0]);

   // store port: one write for receive, one registered read for play-out
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_val;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // a data byte is stored un-escaped; delimiters and escapes store nothing
   always_comb begin
      rd_en   = (state_ff == ST_FETCH) || (state_ff == ST_PLAY);
      rd_addr = rpos_ff;
      wr_en   = !reset && idle && cmd_valid && cmd.action == ACTION_RECEIVE &&
                cmd.rx_byte != cfg.end_code && cmd.rx_byte != cfg.escape_code;
      wr_addr = wpos_ff;
      wr_val  = cmd.rx_byte;
      if (esc_ff && cmd.rx_byte == cfg.escaped_end_code) begin
         wr_val = cfg.end_code;
      end else if (esc_ff && cmd.rx_byte == cfg.escaped_escape_code) begin
         wr_val = cfg.escape_code;
      end
   end

   always_ff @(posedge clock) begin
      logic [15:0]   cur_v;
      logic          esc_v;
      logic [AW-1:0] pos_v;
      logic          wrp_v;
      logic [SW-1:0] rs_v;
      logic [SW-1:0] ws_v;
      logic [AW-1:0] st_v;
      logic [7:0]    b;
      rsp_strobe <= 1'b0;
      if (reset) begin
         state_ff   <= ST_IDLE;
         wslot_ff   <= '0;
         rslot_ff   <= '0;
         wpos_ff    <= '0;
         wrapped_ff <= 1'b0;
         esc_ff     <= 1'b0;
         cur_ff     <= '0;
         for (int i = 0; i < FRAME_SLOTS; i++) begin
            start_ff[i] <= '0;
            len_ff[i]   <= '0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid && cmd.action == ACTION_RECEIVE) begin
                  b     = cmd.rx_byte;
                  cur_v = cur_ff;
                  esc_v = esc_ff;
                  pos_v = wpos_ff;
                  wrp_v = wrapped_ff;
                  rs_v  = rslot_ff;
                  ws_v  = wslot_ff;
                  st_v  = start_ff[rslot_ff];
                  if (esc_v && b != cfg.escaped_end_code &&
                      b != cfg.escaped_escape_code) begin
                     len_ff[ws_v]   <= '0;
                     start_ff[ws_v] <= pos_v;
                     // the oldest slot may be the one being restarted
                     if (ws_v == rs_v) begin
                        st_v = pos_v;
                     end
                     cur_v = '0;
                     esc_v = 1'b0;
                  end
                  if (b == cfg.end_code) begin
                     if (cur_v != '0) begin
                        len_ff[ws_v] <= cur_v;
                        ws_v = ws_nx;
                        if (ws_v == rs_v) begin
                           len_ff[rs_v] <= '0;
                           rs_v = (rs_v == SW'(FRAME_SLOTS - 1)) ? '0 : rs_v + 1'b1;
                        end
                        start_ff[ws_v] <= pos_v;
                        cur_v = '0;
                     end
                  end else begin
                     if (b == cfg.escape_code) begin
                        esc_v = 1'b1;
                     end else begin
                        if ((b == cfg.escaped_end_code || b == cfg.escaped_escape_code) &&
                            esc_v) begin
                           esc_v = 1'b0;
                        end
                        cur_v   = cur_v + 16'd1;
                        if (pos_v == AW'(STORE_BYTES - 1)) begin
                           pos_v = '0;
                           wrp_v = 1'b1;
                        end else begin
                           pos_v = pos_v + 1'b1;
                        end
                     end
                     if (wrp_v && pos_v == st_v) begin
                        len_ff[rs_v] <= '0;
                        rs_v = (rs_v == SW'(FRAME_SLOTS - 1)) ? '0 : rs_v + 1'b1;
                     end
                  end
                  cur_ff     <= cur_v;
                  esc_ff     <= esc_v;
                  wpos_ff    <= pos_v;
                  wrapped_ff <= wrp_v;
                  rslot_ff   <= rs_v;
                  wslot_ff   <= ws_v;
               end else if (cmd_valid) begin
                  if (cmd.max_len == 7'd0) begin
                     rsp_strobe <= 1'b1;
                     rsp_data   <= '{STATUS_NONE, 8'd0, 1'b1, 7'd0};
                  end else begin
                     maxl_ff  <= max_clip;
                     scan_ff  <= rslot_ff;
                     state_ff <= ST_SCAN;
                  end
               end
            end
            // walk one slot a cycle towards the last slot
            ST_SCAN: begin
               if (slen != '0) begin
                  rslot_ff <= scan_ff;
                  state_ff <= ST_CHECK;
               end else if (scan_ff == SW'(FRAME_SLOTS - 1)) begin
                  rsp_strobe <= 1'b1;
                  rsp_data   <= '{STATUS_NONE, 8'd0, 1'b1, 7'd0};
                  state_ff   <= ST_IDLE;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            ST_CHECK: begin
               len_ff[scan_ff] <= '0;
               rslot_ff <= (scan_ff == SW'(FRAME_SLOTS - 1)) ? '0 : scan_ff + 1'b1;
               if (slen < {9'd0, cfg.min_frame_len} || slen > {9'd0, maxl_ff}) begin
                  rsp_strobe <= 1'b1;
                  rsp_data   <= '{STATUS_DROPPED, 8'd0, 1'b1, 7'd0};
                  state_ff   <= ST_IDLE;
               end else begin
                  flen_ff    <= slen[6:0];
                  left_ff    <= slen[6:0];
                  rpos_ff    <= start_ff[scan_ff];
                  wrap_rd_ff <= (span > (AW+1)'(STORE_BYTES));
                  state_ff   <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               rpos_ff  <= (rpos_ff == AW'(STORE_BYTES - 1)) ? '0 : rpos_ff + 1'b1;
               state_ff <= ST_PLAY;
            end
            ST_PLAY: begin
               rsp_strobe <= 1'b1;
               rsp_data   <= '{STATUS_BYTE, rd_data_ff, (left_ff == 7'd1), flen_ff};
               rpos_ff    <= (rpos_ff == AW'(STORE_BYTES - 1)) ? '0 : rpos_ff + 1'b1;
               left_ff    <= left_ff - 7'd1;
               if (left_ff == 7'd1) begin
                  if (wrap_rd_ff) begin
                     wrapped_ff <= 1'b0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// ===== hw/rtl/slip_frame_receive_buffer.sv =====
// Top level: SLIP frame receive buffer with register port and command queue.
//
//  channel   ports                          direction  handshake
//  request   start, busy, req_data          in         start && !busy
//  response  rsp_strobe, rsp_data           out        strobe, one cycle
//  csr       psel..prdata, pready           in/out     APB write, pready high
//
// A request is registered in the queue before the engine sees it.
// A line byte is then handled by the engine in its idle state. A read leaves the
// queue, then the engine scans the slots, checks the size, primes the store
// read and plays the frame out byte by byte.
// The store has one write and one registered read port, which sets the pace.
// Reset is synchronous and clears slots and pointers; the byte store is not
// cleared. The response side cannot stall; busy rises when the queue is full.
`timescale 1ns / 1ps
module slip_frame_receive_buffer #(
   parameter int STORE_BYTES = 256,
   parameter int FRAME_SLOTS = 8,
   parameter int MAX_READ    = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sfrb_pkg::req_type req_data,
   output logic              rsp_strobe,
   output sfrb_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import sfrb_pkg::*;

   cfg_type cfg_ff;
   logic    q_empty, q_full, q_pop;
   req_type q_head;

   assign pready = 1'b1;
   assign busy   = q_full;

   // register writes land on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{8'd192, 8'd219, 8'd220, 8'd221, 7'd4};
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            REG_END_CODE:     cfg_ff.end_code            <= pwdata[7:0];
            REG_ESCAPE_CODE:  cfg_ff.escape_code         <= pwdata[7:0];
            REG_ESC_END_CODE: cfg_ff.escaped_end_code    <= pwdata[7:0];
            REG_ESC_ESC_CODE: cfg_ff.escaped_escape_code <= pwdata[7:0];
            REG_MIN_LEN:      cfg_ff.min_frame_len       <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_END_CODE:     prdata = {24'd0, cfg_ff.end_code};
         REG_ESCAPE_CODE:  prdata = {24'd0, cfg_ff.escape_code};
         REG_ESC_END_CODE: prdata = {24'd0, cfg_ff.escaped_end_code};
         REG_ESC_ESC_CODE: prdata = {24'd0, cfg_ff.escaped_escape_code};
         REG_MIN_LEN:      prdata = {25'd0, cfg_ff.min_frame_len};
         default:          prdata = 32'd0;
      endcase
   end

   // hold accepted requests until the engine is free
   sfrb_cmd_queue #(.DEPTH(2)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (start && !q_full),
      .push_data (req_data),
      .pop       (q_pop),
      .empty     (q_empty),
      .full      (q_full),
      .head      (q_head)
   );

   sfrb_engine #(
      .STORE_BYTES (STORE_BYTES),
      .FRAME_SLOTS (FRAME_SLOTS),
      .MAX_READ    (MAX_READ)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd_valid  (!q_empty),
      .cmd        (q_head),
      .cmd_pop    (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );
endmodule
